@@ hw/rtl/fpexp_pkg.sv @@
package fpexp_pkg;

  // Q5.10 number format.
  localparam int unsigned FRAC_BITS = 10;
  localparam int unsigned VAL_W     = 15;
  localparam int unsigned ARG_W     = 16;

  // Magnitude of an argument that reaches the series (at most 3552).
  localparam int unsigned MAG_W  = 12;
  // Series term and index widths.
  localparam int unsigned TERM_W = 16;
  localparam int unsigned IDX_W  = 5;

  // Reciprocal table: ceil(2^RECIP_SHIFT / i), exact for MAG_W-bit numerators.
  localparam int unsigned RECIP_SHIFT = 17;
  localparam int unsigned RECIP_W     = 17;

  // Reciprocal of the series sum: 2^20 / sum, quotient below 2^RCP_BITS.
  localparam int unsigned RCP_BITS = 11;
  localparam int unsigned CNT_W    = 4;

  localparam logic [VAL_W-1:0] ONE_Q   = 15'd1024;
  localparam logic [VAL_W-1:0] MAX_Q   = 15'h7fff;
  localparam logic [VAL_W-1:0] EXP_ONE = 15'h0adf;
  localparam logic [VAL_W-1:0] ZERO_Q  = 15'd0;

  // Remainder seed: dividend 2^20 shifted down by RCP_BITS.
  localparam logic [VAL_W-1:0] RCP_SEED = 15'd512;

  localparam logic signed [ARG_W-1:0] ARG_ONE = 16'sd1024;
  localparam logic signed [ARG_W-1:0] SAT_HI  = 16'sd3548;
  localparam logic signed [ARG_W-1:0] UNF_LO  = -16'sd3553;

  // Early stop thresholds.
  localparam logic [TERM_W-1:0] TERM_SMALL = 16'd500;
  localparam logic [TERM_W-1:0] TERM_TINY  = 16'd20;
  localparam logic [IDX_W-1:0]  IDX_LATE   = 5'd15;
  localparam logic [IDX_W-1:0]  IDX_FIRST  = 5'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QUO,
    S_TERM,
    S_RCP,
    S_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic q_step;
    logic t_step;
    logic rcp_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic special;
    logic brk;
    logic last;
    logic neg;
    logic rcp_last;
  } sts_t;

  // Rounded-up reciprocals of the series index.
  function automatic logic [RECIP_W-1:0] recip(input logic [IDX_W-1:0] idx);
    logic [RECIP_W-1:0] r;
    unique case (idx)
      5'd2:    r = 17'd65536;
      5'd3:    r = 17'd43691;
      5'd4:    r = 17'd32768;
      5'd5:    r = 17'd26215;
      5'd6:    r = 17'd21846;
      5'd7:    r = 17'd18725;
      5'd8:    r = 17'd16384;
      5'd9:    r = 17'd14564;
      5'd10:   r = 17'd13108;
      5'd11:   r = 17'd11916;
      5'd12:   r = 17'd10923;
      5'd13:   r = 17'd10083;
      5'd14:   r = 17'd9363;
      5'd15:   r = 17'd8739;
      5'd16:   r = 17'd8192;
      5'd17:   r = 17'd7711;
      5'd18:   r = 17'd7282;
      5'd19:   r = 17'd6899;
      5'd20:   r = 17'd6554;
      5'd21:   r = 17'd6242;
      5'd22:   r = 17'd5958;
      5'd23:   r = 17'd5699;
      5'd24:   r = 17'd5462;
      5'd25:   r = 17'd5243;
      5'd26:   r = 17'd5042;
      5'd27:   r = 17'd4855;
      5'd28:   r = 17'd4682;
      5'd29:   r = 17'd4520;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/fpexp_ctrl.sv @@
module fpexp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  fpexp_pkg::sts_t sts,
  output fpexp_pkg::cmd_t cmd
);

  fpexp_pkg::state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpexp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      fpexp_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.special ? fpexp_pkg::S_FIN : fpexp_pkg::S_QUO;
        end
      end
      fpexp_pkg::S_QUO: begin
        cmd.q_step = 1'b1;
        state_nxt  = fpexp_pkg::S_TERM;
      end
      fpexp_pkg::S_TERM: begin
        cmd.t_step = 1'b1;
        if (sts.brk || sts.last) begin
          state_nxt = sts.neg ? fpexp_pkg::S_RCP : fpexp_pkg::S_FIN;
        end else begin
          state_nxt = fpexp_pkg::S_QUO;
        end
      end
      fpexp_pkg::S_RCP: begin
        cmd.rcp_step = 1'b1;
        if (sts.rcp_last) begin
          state_nxt = fpexp_pkg::S_FIN;
        end
      end
      fpexp_pkg::S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = fpexp_pkg::S_IDLE;
        end
      end
      default: state_nxt = fpexp_pkg::S_IDLE;
    endcase
  end

  // The output register holds a beat until the receiver takes it.
  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;
  assign in_stall      = (state_r != fpexp_pkg::S_IDLE);

endmodule

@@ hw/rtl/fpexp_dpath.sv @@
module fpexp_dpath #(
  parameter int unsigned TERM_LIMIT = 30
) (
  input  logic                               clk,
  input  logic signed [fpexp_pkg::ARG_W-1:0] in_argument,
  input  fpexp_pkg::cmd_t                    cmd,
  output fpexp_pkg::sts_t                    sts,
  output logic [fpexp_pkg::VAL_W-1:0]        out_exp_value
);

  localparam int unsigned IW = $clog2(TERM_LIMIT);
  localparam int unsigned QP_W = fpexp_pkg::MAG_W + fpexp_pkg::RECIP_W;
  localparam int unsigned TP_W = fpexp_pkg::TERM_W + fpexp_pkg::MAG_W;

  logic [fpexp_pkg::MAG_W-1:0]    mag_r;
  logic                           neg_r;
  logic [fpexp_pkg::TERM_W-1:0]   term_r;
  logic [fpexp_pkg::VAL_W-1:0]    sum_r;
  logic [IW-1:0]                  idx_r;
  logic [fpexp_pkg::MAG_W-1:0]    q_r;
  logic [fpexp_pkg::VAL_W-1:0]    rem_r;
  logic [fpexp_pkg::RCP_BITS-1:0] quo_r;
  logic [fpexp_pkg::CNT_W-1:0]    cnt_r;
  logic [fpexp_pkg::VAL_W-1:0]    out_r;

  logic                           is_zero, is_one, is_sat, is_unf, special;
  logic [fpexp_pkg::VAL_W-1:0]    spec_val;
  logic [fpexp_pkg::ARG_W-1:0]    arg_abs;
  logic [fpexp_pkg::MAG_W-1:0]    mag_in;
  logic [fpexp_pkg::IDX_W-1:0]    idx_ext;
  logic [QP_W-1:0]                q_prod;
  logic [TP_W-1:0]                t_prod;
  logic [fpexp_pkg::TERM_W-1:0]   term_nxt;
  logic [fpexp_pkg::VAL_W+1:0]    sum_wide;
  logic [fpexp_pkg::VAL_W-1:0]    sum_nxt;
  logic [fpexp_pkg::VAL_W:0]      rem_sh;
  logic                           rem_ge;

  // Fixed answers for the special arguments.
  assign is_zero = (in_argument == '0);
  assign is_one  = (in_argument == fpexp_pkg::ARG_ONE);
  assign is_sat  = (in_argument >= fpexp_pkg::SAT_HI);
  assign is_unf  = (in_argument <= fpexp_pkg::UNF_LO);
  assign special = is_zero || is_one || is_sat || is_unf;

  always_comb begin
    if (is_zero) begin
      spec_val = fpexp_pkg::ONE_Q;
    end else if (is_one) begin
      spec_val = fpexp_pkg::EXP_ONE;
    end else if (is_sat) begin
      spec_val = fpexp_pkg::MAX_Q;
    end else begin
      spec_val = fpexp_pkg::ZERO_Q;
    end
  end

  // Magnitude of the argument; only small magnitudes reach the series.
  assign arg_abs = in_argument[fpexp_pkg::ARG_W-1] ? fpexp_pkg::ARG_W'(-in_argument)
                                                   : fpexp_pkg::ARG_W'(in_argument);
  assign mag_in  = arg_abs[fpexp_pkg::MAG_W-1:0];

  // Quotient mag / i as a multiply by the rounded-up reciprocal.
  assign idx_ext = fpexp_pkg::IDX_W'(idx_r);
  assign q_prod  = QP_W'(mag_r) * QP_W'(fpexp_pkg::recip(idx_ext));

  // Next term, truncated Q6.10 product, and the saturating running sum.
  assign t_prod   = TP_W'(term_r) * TP_W'(q_r);
  assign term_nxt = t_prod[fpexp_pkg::FRAC_BITS +: fpexp_pkg::TERM_W];
  assign sum_wide = (fpexp_pkg::VAL_W+2)'(sum_r) + (fpexp_pkg::VAL_W+2)'(term_nxt);
  assign sum_nxt  = (sum_wide > (fpexp_pkg::VAL_W+2)'(fpexp_pkg::MAX_Q))
                    ? fpexp_pkg::MAX_Q : sum_wide[fpexp_pkg::VAL_W-1:0];

  // One restoring division step of the reciprocal.
  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = (rem_sh >= (fpexp_pkg::VAL_W+1)'(sum_r));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r  <= mag_in;
      neg_r  <= special ? 1'b0 : in_argument[fpexp_pkg::ARG_W-1];
      term_r <= fpexp_pkg::TERM_W'(mag_in);
      sum_r  <= special ? spec_val
                        : fpexp_pkg::VAL_W'(fpexp_pkg::VAL_W'(mag_in) + fpexp_pkg::ONE_Q);
      idx_r  <= IW'(fpexp_pkg::IDX_FIRST);
    end
    if (cmd.q_step) begin
      q_r <= q_prod[fpexp_pkg::RECIP_SHIFT +: fpexp_pkg::MAG_W];
    end
    // The term step also seeds the reciprocal divider.
    if (cmd.t_step) begin
      term_r <= term_nxt;
      sum_r  <= sum_nxt;
      idx_r  <= idx_r + IW'(1);
      rem_r  <= fpexp_pkg::RCP_SEED;
      quo_r  <= '0;
      cnt_r  <= '0;
    end
    if (cmd.rcp_step) begin
      rem_r <= rem_ge ? fpexp_pkg::VAL_W'(rem_sh - (fpexp_pkg::VAL_W+1)'(sum_r))
                      : rem_sh[fpexp_pkg::VAL_W-1:0];
      quo_r <= {quo_r[fpexp_pkg::RCP_BITS-2:0], rem_ge};
      cnt_r <= cnt_r + fpexp_pkg::CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_r <= neg_r ? fpexp_pkg::VAL_W'(quo_r) : sum_r;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts.special  = special;
    sts.brk      = (term_nxt < fpexp_pkg::TERM_SMALL) &&
                   ((idx_ext > fpexp_pkg::IDX_LATE) || (term_nxt < fpexp_pkg::TERM_TINY));
    sts.last     = (idx_r == IW'(TERM_LIMIT - 1));
    sts.neg      = neg_r;
    sts.rcp_last = (cnt_r == fpexp_pkg::CNT_W'(fpexp_pkg::RCP_BITS - 1));
  end

  assign out_exp_value = out_r;

endmodule

@@ hw/rtl/fixed_point_exp_taylor_core.sv @@
// Fixed-point exponential, Q5.10 in and Q5.10 out.
// Input channel: in_valid, in_stall, in_argument (signed Q5.10). A beat is
// taken when in_valid is high and in_stall is low.
// Output channel: out_valid, out_stall, out_exp_value (exp of the argument,
// saturated at 0x7fff). Every input beat gives exactly one output beat.
// Zero, one, and arguments outside the series range are answered at once:
// the load goes straight to the final state, which stores the fixed answer.
// Other arguments run a Taylor series, each term a reciprocal multiply for
// the quotient, then the term multiply and sum, for 1 to TERM_LIMIT-2 terms.
// A negative argument then adds a bit-serial reciprocal divide of 11 bits.
// The early stop ends the series within about a dozen terms.
// One beat is in flight at a time; in_stall is high from acceptance until the
// result enters the output register; the next beat can be taken when in_stall
// falls, while the previous result may still wait. A stalled result holds.
// Reset clears the controller and the output valid; no beat is in flight.
module fixed_point_exp_taylor_core #(
  parameter int unsigned TERM_LIMIT = 30
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [fpexp_pkg::ARG_W-1:0] in_argument,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fpexp_pkg::VAL_W-1:0]        out_exp_value
);

  fpexp_pkg::cmd_t cmd;
  fpexp_pkg::sts_t sts;

  fpexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpexp_dpath #(
    .TERM_LIMIT (TERM_LIMIT)
  ) u_dpath (
    .clk           (clk),
    .in_argument   (in_argument),
    .cmd           (cmd),
    .sts           (sts),
    .out_exp_value (out_exp_value)
  );

`ifndef SYNTHESIS
  // An accepted beat blocks the input until its result is stored.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accepted beat");

  // The datapath gets at most one command per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.q_step, cmd.t_step, cmd.rcp_step, cmd.out_load}))
    else $error("more than one datapath command in a cycle");

  // The reciprocal divider runs only for negative arguments.
  a_rcp_neg: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rcp_step |-> sts.neg)
    else $error("reciprocal step for a non-negative argument");

  // A stored result is presented in the next cycle.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("stored result not presented");
`endif

endmodule

@@ test/fixed_point_exp_taylor_core_test.sv @@
module fixed_point_exp_taylor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SERIES_LIMIT = 30;
  localparam int RANDOM_ITEMS = 1750;
  localparam int DRAIN_CYCLES = 90;

  // One row of the directed table. Rows with a fixed answer carry it, the
  // rest are predicted.
  typedef struct packed {
    logic signed [fpexp_pkg::ARG_W-1:0] arg;
    logic                               fixed;
    logic [fpexp_pkg::VAL_W-1:0]        value;
  } exp_row_t;

  // One outstanding result: the argument it came from and its value.
  typedef struct packed {
    logic signed [fpexp_pkg::ARG_W-1:0] arg;
    logic [fpexp_pkg::VAL_W-1:0]        value;
  } exp_due_t;

  localparam int DIRECTED_ROWS = 22;
  exp_row_t directed [0:DIRECTED_ROWS-1] = '{
    '{16'sd0,             1'b1, fpexp_pkg::ONE_Q},
    '{fpexp_pkg::ARG_ONE, 1'b1, fpexp_pkg::EXP_ONE},
    '{fpexp_pkg::SAT_HI,  1'b1, fpexp_pkg::MAX_Q},
    '{16'sd3549,          1'b1, fpexp_pkg::MAX_Q},
    '{16'sd32767,         1'b1, fpexp_pkg::MAX_Q},
    '{16'sh5555,          1'b1, fpexp_pkg::MAX_Q},
    '{fpexp_pkg::UNF_LO,  1'b1, fpexp_pkg::ZERO_Q},
    '{-16'sd3554,         1'b1, fpexp_pkg::ZERO_Q},
    '{-16'sd32768,        1'b1, fpexp_pkg::ZERO_Q},
    '{16'shaaaa,          1'b1, fpexp_pkg::ZERO_Q},
    '{16'sd3547,          1'b0, fpexp_pkg::ZERO_Q},
    '{-16'sd3552,         1'b0, fpexp_pkg::ZERO_Q},
    '{16'sd1,             1'b0, fpexp_pkg::ZERO_Q},
    '{-16'sd1,            1'b0, fpexp_pkg::ZERO_Q},
    '{16'sd1023,          1'b0, fpexp_pkg::ZERO_Q},
    '{16'sd1025,          1'b0, fpexp_pkg::ZERO_Q},
    '{-16'sd1024,         1'b0, fpexp_pkg::ZERO_Q},
    '{16'sd2048,          1'b0, fpexp_pkg::ZERO_Q},
    '{-16'sd2048,         1'b0, fpexp_pkg::ZERO_Q},
    '{16'sd3000,          1'b0, fpexp_pkg::ZERO_Q},
    '{-16'sd3000,         1'b0, fpexp_pkg::ZERO_Q},
    '{16'sd100,           1'b0, fpexp_pkg::ZERO_Q}
  };

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic signed [fpexp_pkg::ARG_W-1:0] in_argument = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [fpexp_pkg::VAL_W-1:0]        out_exp_value;

  // When set, neither side idles.
  bit steady = 1'b0;

  exp_due_t exp_due [$];
  int sent = 0;
  int checked = 0;
  int mismatches = 0;
  int series_pos = 0;
  int series_neg = 0;

  fixed_point_exp_taylor_core #(
    .TERM_LIMIT(SERIES_LIMIT)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_argument  (in_argument),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_exp_value(out_exp_value)
  );

  always #6 clk = ~clk;

  // Computes exp of a Q5.10 argument: fixed answers first, then the truncated
  // Taylor series on the magnitude, and the reciprocal for a negative input.
  function automatic logic [fpexp_pkg::VAL_W-1:0] taylor_exp(
    input logic signed [fpexp_pkg::ARG_W-1:0] arg);
    logic [31:0] mag;
    logic [31:0] sum;
    logic [31:0] term;
    logic [31:0] quo;
    logic [31:0] prod;
    int unsigned idx;
    bit          done;
    if (arg == 16'sd0) return fpexp_pkg::ONE_Q;
    if (arg == fpexp_pkg::ARG_ONE) return fpexp_pkg::EXP_ONE;
    if (arg >= fpexp_pkg::SAT_HI) return fpexp_pkg::MAX_Q;
    if (arg <= fpexp_pkg::UNF_LO) return fpexp_pkg::ZERO_Q;
    mag = (arg < 0) ? 32'(-int'(arg)) : 32'(int'(arg));
    sum = mag + 32'(fpexp_pkg::ONE_Q);
    term = mag;
    done = 1'b0;
    for (idx = 2; idx < SERIES_LIMIT && !done; idx++) begin
      quo = (mag << fpexp_pkg::FRAC_BITS) / (32'(idx) << fpexp_pkg::FRAC_BITS);
      prod = term * quo;
      term = {1'b0, prod[30:0]} >> fpexp_pkg::FRAC_BITS;
      sum = sum + term;
      if (sum > 32'(fpexp_pkg::MAX_Q)) sum = 32'(fpexp_pkg::MAX_Q);
      // Stop once the term is small and either late in the series or tiny.
      if (term < 32'd500 && (idx > 15 || term < 32'd20)) done = 1'b1;
    end
    if (arg < 0) sum = (32'(fpexp_pkg::ONE_Q) << fpexp_pkg::FRAC_BITS) / sum;
    return sum[fpexp_pkg::VAL_W-1:0];
  endfunction

  // Offers one argument, idling at random first unless steady is set, and records the expected
  // result once the beat is taken.
  task automatic send_argument(input logic signed [fpexp_pkg::ARG_W-1:0] arg,
                               input logic fixed,
                               input logic [fpexp_pkg::VAL_W-1:0] value);
    exp_due_t due;
    while (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      in_argument <= 16'($urandom_range(65535));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_argument <= arg;
    do @(posedge clk); while (in_stall !== 1'b0);
    due.arg = arg;
    due.value = fixed ? value : taylor_exp(arg);
    exp_due.push_back(due);
    sent++;
    if (arg != 16'sd0 && arg != fpexp_pkg::ARG_ONE && arg < fpexp_pkg::SAT_HI &&
        arg > fpexp_pkg::UNF_LO) begin
      if (arg < 0) series_neg++;
      else series_pos++;
    end
    @(negedge clk);
  endtask

  // Holds the input channel quiet until every outstanding result is back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (exp_due.size() != 0) @(negedge clk);
  endtask

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // The result side stalls at random, except in the steady stretch.
  always @(negedge clk) begin
    if (!rst_n || steady) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 14);
  end

  // Each result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    exp_due_t due;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (exp_due.size() == 0) begin
        flag_error($sformatf("unexpected result beat: exp_value %h", out_exp_value));
      end else begin
        due = exp_due.pop_front();
        checked++;
        if (out_exp_value !== due.value)
          flag_error($sformatf("mismatch: argument %0d expected %h got %h",
                               due.arg, due.value, out_exp_value));
      end
    end
  end

  // Main sequence: reset, directed table, random arguments, then drain.
  initial begin
    int n;
    int sel;
    logic signed [fpexp_pkg::ARG_W-1:0] arg;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (n = 0; n < DIRECTED_ROWS; n++)
      send_argument(directed[n].arg, directed[n].fixed, directed[n].value);
    wait_for_results();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 700 && n < 1000);
      if (n == 1200) wait_for_results();
      sel = $urandom_range(99);
      if (sel < 65) begin
        // Anywhere in the series range.
        arg = 16'(int'($urandom_range(7099)) - 3552);
      end else if (sel < 77) begin
        arg = 16'(int'($urandom_range(128)) - 64);
      end else if (sel < 90) begin
        arg = 16'($urandom_range(65535));
      end else begin
        // Around the fixed answers and the range limits.
        case ($urandom_range(9))
          0: arg = 16'sd0;
          1: arg = fpexp_pkg::ARG_ONE;
          2: arg = 16'sd1023;
          3: arg = 16'sd1025;
          4: arg = 16'(int'(fpexp_pkg::SAT_HI) - int'($urandom_range(2)));
          5: arg = 16'(int'(fpexp_pkg::SAT_HI) + int'($urandom_range(2)));
          6: arg = 16'(int'(fpexp_pkg::UNF_LO) + int'($urandom_range(2)));
          7: arg = 16'(int'(fpexp_pkg::UNF_LO) - int'($urandom_range(2)));
          8: arg = -16'sd1;
          default: arg = 16'sd1;
        endcase
      end
      send_argument(arg, 1'b0, fpexp_pkg::ZERO_Q);
    end
    steady = 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d argument beats (%0d positive and %0d negative series runs),",
             sent, series_pos, series_neg);
    $display("checked %0d result beats, %0d errors.", checked, mismatches);
    if (mismatches == 0) begin
      $display("** fixed_point_exp_taylor_core: PASSED **");
    end else begin
      $display("** fixed_point_exp_taylor_core: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #24_000_000;
    $display("timeout with %0d results outstanding", exp_due.size());
    $display("** fixed_point_exp_taylor_core: FAILED **");
    $finish;
  end

endmodule
